// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spq_pkg : shared types and codes for the sorted priority queue
// Operation codes, status codes, controller state and command bundle.
// ============================================================================
package spq_pkg;

    // operation codes on the func field; code 3 behaves as a peek
    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the captured operation to the list
    } t_cmd;

endpackage

// ===== sv/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Sequence: the accepted item is captured in IDLE, applied to the cell array
//   in EXEC, and the result valid flag is registered as the array updates.
// Flow: a new item is accepted only in IDLE, never while an item is in EXEC,
//   and the whole compare-and-shift cell array updates at once in EXEC.
// Reset: synchronous, active low; clears the controller and the fill count.
//   Slot contents are undefined until written; no clearing pass is needed.
// ============================================================================
// sorted_priority_queue_core : sorted-list min-priority queue of search states
// Top level: controller plus cell-array datapath. Every item (push, pop,
// peek) returns the head entry, the entry count and a status code.
// ============================================================================
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH   = 64,   // number of slots, 2..127
    parameter int PRIORITY_BITS = 16    // stored priority width, 4..32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_new_priority,
    input  logic [63:0] i_new_board,
    input  logic [7:0]  i_new_move,
    input  logic [1:0]  i_new_col,
    input  logic [1:0]  i_new_row,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_head_priority,
    output logic [63:0] o_head_board,
    output logic [7:0]  o_head_move,
    output logic [1:0]  o_head_col,
    output logic [1:0]  o_head_row,
    output logic        o_is_empty,
    output logic [6:0]  o_entry_count,
    output logic [1:0]  o_status
);

    // Flow: an item is captured at accept (IDLE), applied to the cell array
    // in EXEC, and the result valid flag rises as the array updates. The
    // head fields come straight from cell 0, which only changes in EXEC, so
    // they hold steady while a result waits. A new item is taken in the
    // same cycle the waiting result drains.
    spq_pkg::t_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Insertion: the head yields only to a strictly lower priority; other
    // slots keep entries of strictly lower priority ahead of the new one,
    // so a new entry lands before equal entries except the head.
    spq_dp #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_func          (i_func),
        .i_new_priority  (i_new_priority),
        .i_new_board     (i_new_board),
        .i_new_move      (i_new_move),
        .i_new_col       (i_new_col),
        .i_new_row       (i_new_row),
        .o_head_priority (o_head_priority),
        .o_head_board    (o_head_board),
        .o_head_move     (o_head_move),
        .o_head_col      (o_head_col),
        .o_head_row      (o_head_row),
        .o_is_empty      (o_is_empty),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

endmodule

// ===== sv/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spq_ctrl : sequencing controller
// Two-state machine (capture, execute) plus the result valid flag.
// ============================================================================
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output spq_pkg::t_cmd     o_cmd
);

    spq_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_accept;

    // result slot is free now or drains at this edge
    assign o_in_ready  = (r_state == spq_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.load = w_accept;
    assign o_cmd.exec = (r_state == spq_pkg::S_EXEC);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                n_state = spq_pkg::S_IDLE;
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (r_state == spq_pkg::S_EXEC) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/spq_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spq_dp : compare-and-shift cell array datapath
// One cell per slot; each cell compares against the new priority and
// either keeps, loads the new entry, or takes its neighbor's entry.
// ============================================================================
module spq_dp #(
    parameter int QUEUE_DEPTH   = 64,
    parameter int PRIORITY_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_cmd     i_cmd,
    input  logic [1:0]        i_func,
    input  logic [15:0]       i_new_priority,
    input  logic [63:0]       i_new_board,
    input  logic [7:0]        i_new_move,
    input  logic [1:0]        i_new_col,
    input  logic [1:0]        i_new_row,
    output logic [15:0]       o_head_priority,
    output logic [63:0]       o_head_board,
    output logic [7:0]        o_head_move,
    output logic [1:0]        o_head_col,
    output logic [1:0]        o_head_row,
    output logic              o_is_empty,
    output logic [6:0]        o_entry_count,
    output logic [1:0]        o_status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // captured item
    logic [1:0]               r_func;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [63:0]              r_board;
    logic [7:0]               r_move;
    logic [1:0]               r_col;
    logic [1:0]               r_row;

    // cell array, slot 0 is the head
    logic [PRIORITY_BITS-1:0] r_c_prio  [QUEUE_DEPTH];
    logic [63:0]              r_c_board [QUEUE_DEPTH];
    logic [7:0]               r_c_move  [QUEUE_DEPTH];
    logic [1:0]               r_c_col   [QUEUE_DEPTH];
    logic [1:0]               r_c_row   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] n_c_prio  [QUEUE_DEPTH];
    logic [63:0]              n_c_board [QUEUE_DEPTH];
    logic [7:0]               n_c_move  [QUEUE_DEPTH];
    logic [1:0]               n_c_col   [QUEUE_DEPTH];
    logic [1:0]               n_c_row   [QUEUE_DEPTH];

    logic [CW-1:0]            r_fill, n_fill;
    spq_pkg::t_status         r_status, n_status;

    logic [QUEUE_DEPTH-1:0]   w_valid;
    logic [QUEUE_DEPTH-1:0]   w_pass;     // entry stays ahead of the new one
    logic                     w_empty, w_full;
    logic                     w_push, w_pop;
    logic [31:0]              w_prio_in_ext;
    logic [31:0]              w_head_ext;
    logic [31:0]              w_fill_ext;

    assign w_prio_in_ext = 32'(i_new_priority);
    assign w_empty       = (r_fill == '0);
    assign w_full        = (r_fill == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_prio  <= w_prio_in_ext[PRIORITY_BITS-1:0];
            r_board <= i_new_board;
            r_move  <= i_new_move;
            r_col   <= i_new_col;
            r_row   <= i_new_row;
        end
    end

    // per-cell compare; the head yields only to a strictly lower priority,
    // other slots yield to an equal or lower one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_valid[i] = (CW'(i) < r_fill);
        end
        w_pass[0] = w_valid[0] && !(r_prio < r_c_prio[0]);
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            w_pass[i] = w_valid[i] && (r_c_prio[i] < r_prio);
        end
    end

    always_comb begin
        w_push   = 1'b0;
        w_pop    = 1'b0;
        n_status = spq_pkg::STAT_OK;
        n_fill   = r_fill;
        unique case (r_func)
            spq_pkg::FUNC_PUSH: begin
                if (w_full) begin
                    n_status = spq_pkg::STAT_PUSH_FULL;
                end else begin
                    w_push = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
            end
            spq_pkg::FUNC_POP: begin
                if (w_empty) begin
                    n_status = spq_pkg::STAT_POP_EMPTY;
                end else begin
                    w_pop  = 1'b1;
                    n_fill = r_fill - 1'b1;
                end
            end
            default: begin
                n_status = spq_pkg::STAT_OK;   // peek
            end
        endcase
    end

    always_comb begin
        n_c_prio  = r_c_prio;
        n_c_board = r_c_board;
        n_c_move  = r_c_move;
        n_c_col   = r_c_col;
        n_c_row   = r_c_row;
        if (w_push) begin
            if (!w_pass[0]) begin
                n_c_prio[0]  = r_prio;
                n_c_board[0] = r_board;
                n_c_move[0]  = r_move;
                n_c_col[0]   = r_col;
                n_c_row[0]   = r_row;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (!w_pass[i]) begin
                    if (w_pass[i-1]) begin
                        n_c_prio[i]  = r_prio;
                        n_c_board[i] = r_board;
                        n_c_move[i]  = r_move;
                        n_c_col[i]   = r_col;
                        n_c_row[i]   = r_row;
                    end else begin
                        n_c_prio[i]  = r_c_prio[i-1];
                        n_c_board[i] = r_c_board[i-1];
                        n_c_move[i]  = r_c_move[i-1];
                        n_c_col[i]   = r_c_col[i-1];
                        n_c_row[i]   = r_c_row[i-1];
                    end
                end
            end
        end else if (w_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_c_prio[i]  = r_c_prio[i+1];
                n_c_board[i] = r_c_board[i+1];
                n_c_move[i]  = r_c_move[i+1];
                n_c_col[i]   = r_c_col[i+1];
                n_c_row[i]   = r_c_row[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_c_prio  <= n_c_prio;
            r_c_board <= n_c_board;
            r_c_move  <= n_c_move;
            r_c_col   <= n_c_col;
            r_c_row   <= n_c_row;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.exec) begin
            r_fill <= n_fill;
        end
    end

    // head fields read zero on an empty queue
    assign w_head_ext      = 32'(r_c_prio[0]);
    assign w_fill_ext      = 32'(r_fill);
    assign o_head_priority = w_empty ? 16'd0 : w_head_ext[15:0];
    assign o_head_board    = w_empty ? 64'd0 : r_c_board[0];
    assign o_head_move     = w_empty ? 8'd0  : r_c_move[0];
    assign o_head_col      = w_empty ? 2'd0  : r_c_col[0];
    assign o_head_row      = w_empty ? 2'd0  : r_c_row[0];
    assign o_is_empty      = w_empty;
    assign o_entry_count   = w_fill_ext[6:0];
    assign o_status        = r_status;

endmodule

// ===== sv/spq_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spq_checker : port-level checks for the sorted priority queue
// Watches the top-level ports only; attached by bind.
// ============================================================================
module spq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_func,
    input logic [15:0] i_new_priority,
    input logic [63:0] i_new_board,
    input logic [7:0]  i_new_move,
    input logic [1:0]  i_new_col,
    input logic [1:0]  i_new_row,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_head_priority,
    input logic [63:0] o_head_board,
    input logic [7:0]  o_head_move,
    input logic [1:0]  o_head_col,
    input logic [1:0]  o_head_row,
    input logic        o_is_empty,
    input logic [6:0]  o_entry_count,
    input logic [1:0]  o_status
);

    // stalled result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_head_priority) && $stable(o_head_board) &&
            $stable(o_head_move) && $stable(o_status) && $stable(o_entry_count))
        else $error("stalled result changed");

    // after an accepted item the result valid flag first reads low, then high
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid ##1 o_out_valid)
        else $error("result timing broken");

    // empty queue shows zero head fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_empty |-> (o_head_priority == 16'd0) && (o_head_board == 64'd0) &&
            (o_head_move == 8'd0) && (o_head_col == 2'd0) && (o_head_row == 2'd0))
        else $error("empty queue shows a head entry");

    // a rejected pop leaves the queue empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == spq_pkg::STAT_POP_EMPTY) |-> o_is_empty)
        else $error("pop-on-empty status with entries held");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
